@@ hw/rtl/rfp_pkg.sv @@
// Shared types and constants for the request frame parser.
package rfp_pkg;

  localparam int MAX_MSG = 4096;

  localparam int DATA_W    = 8;
  localparam int COUNT_W   = 13;
  localparam int ARG_IDX_W = 12;
  localparam int VERDICT_W = 3;
  localparam int LEN_W     = 32;

  // Reset value of the max_args register, saturated to its 13-bit range.
  localparam logic [COUNT_W-1:0] MAX_ARGS_RESET =
    (MAX_MSG > 8191) ? 13'h1FFF : COUNT_W'(MAX_MSG);

  localparam logic [VERDICT_W-1:0] VERDICT_BAD     = 3'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_GET     = 3'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_SET     = 3'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_DEL     = 3'd3;
  localparam logic [VERDICT_W-1:0] VERDICT_UNKNOWN = 3'd4;

  // Bit positions of the command candidates in the name match vector.
  localparam int CAND_GET = 0;
  localparam int CAND_SET = 1;
  localparam int CAND_DEL = 2;
  localparam int NUM_CAND = 3;
  localparam int NAME_LEN = 3;

  localparam logic [DATA_W-1:0] CMD_NAME [NUM_CAND][NAME_LEN] = '{
    '{"g", "e", "t"},
    '{"s", "e", "t"},
    '{"d", "e", "l"}
  };

  typedef enum logic [4:0] {
    PH_COUNT = 5'b00001,
    PH_LEN   = 5'b00010,
    PH_BODY  = 5'b00100,
    PH_DONE  = 5'b01000,
    PH_BAD   = 5'b10000
  } phase_t;

endpackage

@@ hw/rtl/rfp_req_if.sv @@
// Request channel: one raw byte of a request frame per transfer.
interface rfp_req_if
  import rfp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ hw/rtl/rfp_rsp_if.sv @@
// Result channel: each request byte echoed with argument marks and verdict.
interface rfp_rsp_if
  import rfp_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [DATA_W-1:0]    out_byte;
  logic                 in_argument;
  logic [ARG_IDX_W-1:0] arg_index;
  logic                 arg_first;
  logic                 arg_last;
  logic                 frame_end;
  logic [VERDICT_W-1:0] verdict;

  modport source (
    output valid, output out_byte, output in_argument, output arg_index,
    output arg_first, output arg_last, output frame_end, output verdict,
    input ready
  );
  modport sink (
    input valid, input out_byte, input in_argument, input arg_index,
    input arg_first, input arg_last, input frame_end, input verdict,
    output ready
  );
endinterface

@@ hw/rtl/request_frame_parser_unit.sv @@
// A result is registered and valid in the cycle after its request byte is accepted.
// Throughput: one byte per cycle; the single output register takes a new
// result whenever it is empty or its result is taken in the same cycle.
// Reset (synchronous, active high) returns the parser to the count header,
// clears all frame state and loads max_args with 4096.
module request_frame_parser_unit
  import rfp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  rfp_req_if.sink            req,
  rfp_rsp_if.source          rsp,
  input  logic               cfg_write_en,
  input  logic [COUNT_W-1:0] cfg_write_data
);

  logic [COUNT_W-1:0] max_args;

  phase_t             phase, phase_next;
  logic [23:0]        hdr_shift;
  logic [1:0]         hdr_cnt, hdr_cnt_next;
  logic [COUNT_W-1:0] requested_args, requested_args_next;
  logic [COUNT_W-1:0] args_left, args_left_next;
  logic [LEN_W-1:0]   body_left, body_left_next;
  logic [COUNT_W-1:0] current_arg, current_arg_next;
  logic [NUM_CAND-1:0] name_match, name_match_next;
  logic [2:0]         name_length, name_length_next;
  logic               first_pending, first_pending_next;

  logic                 rsp_valid;
  logic                 accept;
  logic [LEN_W-1:0]     hdr_word;
  logic                 hdr_done;
  logic [COUNT_W-1:0]   args_dec;
  logic [COUNT_W-1:0]   cur_inc;
  phase_t               phase_fin;
  logic                 in_arg_c, first_c, lastmark_c;
  logic [ARG_IDX_W-1:0] idx_c;
  logic [VERDICT_W-1:0] verdict_c;

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign rsp.valid = rsp_valid;

  // The header word completes with the incoming byte as its top byte.
  assign hdr_word = {req.data_byte, hdr_shift};
  assign hdr_done = (hdr_cnt == 2'd3);

  // Closing an argument: one fewer left, one more completed.
  assign args_dec  = (args_left != '0) ? args_left - COUNT_W'(1) : args_left;
  assign cur_inc   = (current_arg == '1) ? current_arg : current_arg + COUNT_W'(1);
  assign phase_fin = (args_dec != '0) ? PH_LEN : PH_DONE;

  always_comb begin
    phase_next          = phase;
    hdr_cnt_next        = hdr_cnt;
    requested_args_next = requested_args;
    args_left_next      = args_left;
    body_left_next      = body_left;
    current_arg_next    = current_arg;
    name_match_next     = name_match;
    name_length_next    = name_length;
    first_pending_next  = first_pending;
    in_arg_c            = 1'b0;
    first_c             = 1'b0;
    lastmark_c          = 1'b0;
    verdict_c           = VERDICT_BAD;
    idx_c = current_arg[COUNT_W-1] ? '1 : current_arg[ARG_IDX_W-1:0];

    unique case (phase)
      PH_COUNT: begin
        idx_c        = '0;
        hdr_cnt_next = hdr_cnt + 2'd1;
        if (hdr_done) begin
          if ((|hdr_word[LEN_W-1:COUNT_W]) || (hdr_word[COUNT_W-1:0] > max_args)) begin
            phase_next = PH_BAD;
          end else begin
            requested_args_next = hdr_word[COUNT_W-1:0];
            args_left_next      = hdr_word[COUNT_W-1:0];
            current_arg_next    = '0;
            phase_next = (hdr_word[COUNT_W-1:0] != '0) ? PH_LEN : PH_DONE;
          end
        end
      end
      PH_LEN: begin
        hdr_cnt_next = hdr_cnt + 2'd1;
        if (hdr_done) begin
          body_left_next = hdr_word;
          if (hdr_word == '0) begin
            args_left_next   = args_dec;
            current_arg_next = cur_inc;
            phase_next       = phase_fin;
          end else begin
            phase_next         = PH_BODY;
            first_pending_next = 1'b1;
          end
        end
      end
      PH_BODY: begin
        in_arg_c           = 1'b1;
        first_c            = first_pending;
        first_pending_next = 1'b0;
        lastmark_c         = (body_left == LEN_W'(1));
        // Only argument 0 carries the command name.
        if (current_arg == '0) begin
          if (name_length < 3'd3) begin
            for (int k = 0; k < NUM_CAND; k++) begin
              if (CMD_NAME[k][name_length[1:0]] != req.data_byte) begin
                name_match_next[k] = 1'b0;
              end
            end
          end else begin
            name_match_next = '0;
          end
          if (name_length < 3'd4) begin
            name_length_next = name_length + 3'd1;
          end
        end
        if (body_left != '0) begin
          body_left_next = body_left - LEN_W'(1);
        end
        if (body_left <= LEN_W'(1)) begin
          args_left_next   = args_dec;
          current_arg_next = cur_inc;
          phase_next       = phase_fin;
        end
      end
      PH_DONE: begin
        phase_next = PH_BAD;
      end
      PH_BAD: begin
        phase_next = PH_BAD;
      end
      default: begin
        phase_next = PH_BAD;
      end
    endcase

    if (req.last_byte) begin
      if (phase_next != PH_DONE) begin
        verdict_c = VERDICT_BAD;
      end else if (name_length_next == 3'd3 && requested_args_next == COUNT_W'(2) &&
                   name_match_next[CAND_GET]) begin
        verdict_c = VERDICT_GET;
      end else if (name_length_next == 3'd3 && requested_args_next == COUNT_W'(3) &&
                   name_match_next[CAND_SET]) begin
        verdict_c = VERDICT_SET;
      end else if (name_length_next == 3'd3 && requested_args_next == COUNT_W'(2) &&
                   name_match_next[CAND_DEL]) begin
        verdict_c = VERDICT_DEL;
      end else begin
        verdict_c = VERDICT_UNKNOWN;
      end
      // The final byte returns the parser to the start of a new request.
      phase_next          = PH_COUNT;
      hdr_cnt_next        = '0;
      requested_args_next = '0;
      args_left_next      = '0;
      body_left_next      = '0;
      current_arg_next    = '0;
      name_match_next     = '1;
      name_length_next    = '0;
      first_pending_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_args       <= MAX_ARGS_RESET;
      phase          <= PH_COUNT;
      hdr_cnt        <= '0;
      requested_args <= '0;
      args_left      <= '0;
      body_left      <= '0;
      current_arg    <= '0;
      name_match     <= '1;
      name_length    <= '0;
      first_pending  <= 1'b0;
      rsp_valid      <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        max_args <= cfg_write_data;
      end
      if (accept) begin
        phase          <= phase_next;
        hdr_cnt        <= hdr_cnt_next;
        requested_args <= requested_args_next;
        args_left      <= args_left_next;
        body_left      <= body_left_next;
        current_arg    <= current_arg_next;
        name_match     <= name_match_next;
        name_length    <= name_length_next;
        first_pending  <= first_pending_next;
        rsp_valid      <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hdr_shift       <= hdr_word[LEN_W-1:8];
      rsp.out_byte    <= req.data_byte;
      rsp.in_argument <= in_arg_c;
      rsp.arg_index   <= idx_c;
      rsp.arg_first   <= first_c;
      rsp.arg_last    <= lastmark_c;
      rsp.frame_end   <= req.last_byte;
      rsp.verdict     <= verdict_c;
    end
  end

`ifndef SYNTH
  a_verdict_only_at_end: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.frame_end |-> rsp.verdict == VERDICT_BAD)
    else $error("verdict given on a byte that does not end the request");

  a_marks_inside_body: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.arg_first || rsp.arg_last) |-> rsp.in_argument)
    else $error("argument boundary mark outside an argument body");

  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && req.last_byte |=> phase == PH_COUNT && hdr_cnt == 2'd0)
    else $error("parser did not return to the count header after a final byte");

  a_body_end_closes: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_BODY && body_left == LEN_W'(1) |=>
      phase == PH_LEN || phase == PH_DONE || phase == PH_COUNT)
    else $error("argument body did not close on its last byte");
`endif

endmodule
